// ===== hdl/hvw_pkg.sv =====
// Shared types, constants and the step program of the haptic virtual world torque core.
package hvw_pkg;

  localparam logic [2:0] MODE_WALL               = 3'd0;
  localparam logic [2:0] MODE_SPRING             = 3'd1;
  localparam logic [2:0] MODE_SPRING_DAMPER      = 3'd2;
  localparam logic [2:0] MODE_WALL_DAMPER        = 3'd3;
  localparam logic [2:0] MODE_SPRING_MASS        = 3'd4;
  localparam logic [2:0] MODE_SPRING_MASS_DAMPER = 3'd5;

  localparam logic [1:0] REG_WORLD_MODE      = 2'd0;
  localparam logic [1:0] REG_SPRING_K        = 2'd1;
  localparam logic [1:0] REG_INVERSE_INERTIA = 2'd2;
  localparam logic [1:0] REG_STEP_TIME       = 2'd3;

  localparam int WALL_GAIN   = 500;
  localparam int SPRING_GAIN = 10;
  localparam int DAMP_SHIFT  = 2;
  localparam int STEP_RESET_NUM = 500;
  localparam int STEP_RESET_DEN = 1000;

  typedef enum logic [2:0] {
    OPA_T, OPA_K, OPA_B, OPA_G, OPA_TG, OPA_WALL, OPA_SPRING, OPA_DAMP
  } opa_t;

  typedef enum logic [2:0] {
    OPB_K, OPB_IJ, OPB_X2, OPB_ANG, OPB_VEL, OPB_X1_ANG, OPB_ANG_X1N, OPB_VEL_X2N
  } opb_t;

  typedef enum logic [2:0] {
    POST_B, POST_G, POST_TG, POST_X1N, POST_X2N_NEW, POST_X2N_ACC, POST_TQ_NEG, POST_TQ_SUB
  } post_t;

  typedef struct packed {
    logic  valid;
    opa_t  a;
    opb_t  b;
    post_t post;
  } uop_t;

  typedef struct packed {
    logic  load;
    logic  mul_start;
    opa_t  a_sel;
    opb_t  b_sel;
    logic  post_en;
    post_t post;
    logic  out_load;
    logic  commit;
  } hvw_cmd_t;

  typedef struct packed {
    logic ang_neg;
    logic mul_done;
  } hvw_status_t;

  function automatic uop_t mk(input opa_t a, input opb_t b, input post_t post);
    uop_t u;
    u.valid = 1'b1;
    u.a = a;
    u.b = b;
    u.post = post;
    return u;
  endfunction

  // Returns the multiply step at position idx of the program of a world.
  function automatic uop_t uop(input logic [2:0] mode, input logic [3:0] idx);
    uop_t u;
    u.valid = 1'b0;
    u.a = OPA_T;
    u.b = OPB_ANG;
    u.post = POST_TQ_NEG;
    case (mode)
      MODE_WALL: begin
        if (idx == 4'd0) u = mk(OPA_WALL, OPB_ANG, POST_TQ_NEG);
      end
      MODE_SPRING: begin
        if (idx == 4'd0) u = mk(OPA_SPRING, OPB_ANG, POST_TQ_NEG);
      end
      MODE_SPRING_DAMPER: begin
        if (idx == 4'd0) u = mk(OPA_SPRING, OPB_ANG, POST_TQ_NEG);
        else if (idx == 4'd1) u = mk(OPA_DAMP, OPB_VEL, POST_TQ_SUB);
      end
      MODE_WALL_DAMPER: begin
        if (idx == 4'd0) u = mk(OPA_WALL, OPB_ANG, POST_TQ_NEG);
        else if (idx == 4'd1) u = mk(OPA_WALL, OPB_VEL, POST_TQ_SUB);
      end
      MODE_SPRING_MASS: begin
        case (idx)
          4'd0: u = mk(OPA_T, OPB_K, POST_B);
          4'd1: u = mk(OPA_B, OPB_IJ, POST_G);
          4'd2: u = mk(OPA_T, OPB_X2, POST_X1N);
          4'd3: u = mk(OPA_G, OPB_X1_ANG, POST_X2N_NEW);
          4'd4: u = mk(OPA_K, OPB_ANG_X1N, POST_TQ_NEG);
          default: u.valid = 1'b0;
        endcase
      end
      MODE_SPRING_MASS_DAMPER: begin
        case (idx)
          4'd0: u = mk(OPA_T, OPB_K, POST_B);
          4'd1: u = mk(OPA_B, OPB_IJ, POST_G);
          4'd2: u = mk(OPA_T, OPB_X2, POST_X1N);
          4'd3: u = mk(OPA_G, OPB_X1_ANG, POST_X2N_NEW);
          4'd4: u = mk(OPA_T, OPB_K, POST_TG);
          4'd5: u = mk(OPA_TG, OPB_X2, POST_X2N_ACC);
          4'd6: u = mk(OPA_K, OPB_ANG_X1N, POST_TQ_NEG);
          4'd7: u = mk(OPA_B, OPB_VEL_X2N, POST_TQ_SUB);
          default: u.valid = 1'b0;
        endcase
        // The T*g product takes g, not k, as its second operand.
        if (idx == 4'd4) u.b = OPB_K;
      end
      default: u.valid = 1'b0;
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/hvw_mul.sv =====
// Multi-cycle saturating fixed-point multiplier built from four half-width partial products.
module hvw_mul
  import hvw_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  parameter int OP_WIDTH = 33
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [OP_WIDTH-1:0]   opa,
  input  logic signed [OP_WIDTH-1:0]   opb,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         done
);

  localparam int H = OP_WIDTH / 2;
  localparam int MW = 2 * H;
  localparam int AW = 2 * MW;
  localparam logic [AW-1:0] LIM_NEG = AW'(1) << (DATA_WIDTH - 1);
  localparam logic [AW-1:0] LIM_POS = LIM_NEG - AW'(1);

  logic                busy;
  logic [2:0]          cnt;
  logic                neg;
  logic [MW-1:0]       ma;
  logic [MW-1:0]       mb;
  logic [AW-1:0]       acc;

  logic signed [OP_WIDTH-1:0]   a_mag;
  logic signed [OP_WIDTH-1:0]   b_mag;
  logic [H-1:0]                 da;
  logic [H-1:0]                 db;
  logic [MW-1:0]                pp;
  logic [AW-1:0]                pp_sh;
  logic [AW-1:0]                r;
  logic [AW-1:0]                lim;
  logic [AW-1:0]                rs;
  logic [DATA_WIDTH-1:0]        rd;

  always_comb begin
    a_mag = opa[OP_WIDTH-1] ? -opa : opa;
    b_mag = opb[OP_WIDTH-1] ? -opb : opb;
    da = cnt[0] ? ma[MW-1:H] : ma[H-1:0];
    db = cnt[1] ? mb[MW-1:H] : mb[H-1:0];
    pp = MW'(da) * MW'(db);
    if (cnt[0] && cnt[1]) begin
      pp_sh = AW'(pp) << MW;
    end else if (cnt[0] || cnt[1]) begin
      pp_sh = AW'(pp) << H;
    end else begin
      pp_sh = AW'(pp);
    end
    r = acc >> FRAC_BITS;
    lim = neg ? LIM_NEG : LIM_POS;
    rs = (r > lim) ? lim : r;
    rd = rs[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        if (cnt[2]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= opa[OP_WIDTH-1] ^ opb[OP_WIDTH-1];
      ma <= MW'(a_mag);
      mb <= MW'(b_mag);
      acc <= '0;
    end else if (busy) begin
      if (cnt[2]) begin
        result <= neg ? -$signed(rd) : $signed(rd);
      end else begin
        acc <= acc + pp_sh;
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("multiplier done without a running product");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier still busy when done");

endmodule

// ===== hdl/hvw_datapath.sv =====
// Datapath: input and mass state registers, operand selection, saturating arithmetic.
module hvw_datapath
  import hvw_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [DATA_WIDTH-1:0] angle,
  input  logic signed [DATA_WIDTH-1:0] velocity,
  input  logic [31:0]                  spring_k,
  input  logic [31:0]                  inverse_inertia,
  input  logic [15:0]                  step_time,
  input  logic                         clear_mass,
  input  hvw_cmd_t                     cmd,
  output hvw_status_t                  status,
  output logic signed [DATA_WIDTH-1:0] torque
);

  localparam int OW_BASE = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int OW = (FRAC_BITS + 9 > OW_BASE) ? FRAC_BITS + 9 : OW_BASE;
  localparam int SW = OW + 1;
  localparam logic signed [SW-1:0] C_WALL = SW'(WALL_GAIN) << FRAC_BITS;
  localparam logic signed [SW-1:0] C_SPRING = SW'(SPRING_GAIN) << FRAC_BITS;
  localparam logic signed [SW-1:0] C_DAMP = SW'(1) << (FRAC_BITS - DAMP_SHIFT);
  localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] ang;
  logic signed [DATA_WIDTH-1:0] vel;
  logic signed [DATA_WIDTH-1:0] x1;
  logic signed [DATA_WIDTH-1:0] x2;
  logic signed [DATA_WIDTH-1:0] b;
  logic signed [DATA_WIDTH-1:0] g;
  logic signed [DATA_WIDTH-1:0] tg;
  logic signed [DATA_WIDTH-1:0] x1n;
  logic signed [DATA_WIDTH-1:0] x2n;
  logic signed [DATA_WIDTH-1:0] tq;

  logic signed [DATA_WIDTH-1:0] p;
  logic                         mul_done;
  logic signed [SW-1:0]         opa;
  logic signed [SW-1:0]         opb;
  logic signed [DATA_WIDTH-1:0] d_x1_ang;
  logic signed [DATA_WIDTH-1:0] d_ang_x1n;
  logic signed [DATA_WIDTH-1:0] d_vel_x2n;

  function automatic logic signed [DATA_WIDTH-1:0] sat_add(
    input logic signed [DATA_WIDTH-1:0] x,
    input logic signed [DATA_WIDTH-1:0] y
  );
    logic [DATA_WIDTH:0] s;
    s = {x[DATA_WIDTH-1], x} + {y[DATA_WIDTH-1], y};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? VMIN : VMAX;
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
    input logic signed [DATA_WIDTH-1:0] x,
    input logic signed [DATA_WIDTH-1:0] y
  );
    logic [DATA_WIDTH:0] s;
    s = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) return s[DATA_WIDTH] ? VMIN : VMAX;
    return s[DATA_WIDTH-1:0];
  endfunction

  always_comb begin
    d_x1_ang = sat_sub(x1, ang);
    d_ang_x1n = sat_sub(ang, x1n);
    d_vel_x2n = sat_sub(vel, x2n);
    case (cmd.a_sel)
      OPA_T:      opa = SW'(step_time);
      OPA_K:      opa = SW'(spring_k);
      OPA_B:      opa = SW'(b);
      OPA_G:      opa = SW'(g);
      OPA_TG:     opa = SW'(tg);
      OPA_WALL:   opa = C_WALL;
      OPA_SPRING: opa = C_SPRING;
      OPA_DAMP:   opa = C_DAMP;
      default:    opa = '0;
    endcase
    case (cmd.b_sel)
      OPB_K:       opb = (cmd.a_sel == OPA_T && cmd.post == POST_TG) ? SW'(g) : SW'(spring_k);
      OPB_IJ:      opb = SW'(inverse_inertia);
      OPB_X2:      opb = SW'(x2);
      OPB_ANG:     opb = SW'(ang);
      OPB_VEL:     opb = SW'(vel);
      OPB_X1_ANG:  opb = SW'(d_x1_ang);
      OPB_ANG_X1N: opb = SW'(d_ang_x1n);
      OPB_VEL_X2N: opb = SW'(d_vel_x2n);
      default:     opb = '0;
    endcase
    status.ang_neg = ang[DATA_WIDTH-1];
    status.mul_done = mul_done;
  end

  hvw_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS(FRAC_BITS),
    .OP_WIDTH(SW)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .start(cmd.mul_start),
    .opa(opa),
    .opb(opb),
    .result(p),
    .done(mul_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
    end else if (clear_mass) begin
      x1 <= '0;
      x2 <= '0;
    end else if (cmd.commit) begin
      x1 <= x1n;
      x2 <= x2n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ang <= angle;
      vel <= velocity;
      tq <= '0;
    end else if (cmd.post_en) begin
      case (cmd.post)
        POST_B:       b <= p;
        POST_G:       g <= p;
        POST_TG:      tg <= p;
        POST_X1N:     x1n <= sat_add(x1, p);
        POST_X2N_NEW: x2n <= sat_sub(x2, p);
        POST_X2N_ACC: x2n <= sat_sub(x2n, p);
        POST_TQ_NEG:  tq <= sat_sub('0, p);
        POST_TQ_SUB:  tq <= sat_sub(tq, p);
        default:      tq <= tq;
      endcase
    end
    if (cmd.out_load) begin
      torque <= tq;
    end
  end

endmodule

// ===== hdl/hvw_ctrl.sv =====
// Controller state machine: request handshakes and sequencing of the multiply steps.
module hvw_ctrl
  import hvw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  world_mode,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  hvw_status_t status,
  output hvw_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [3:0] idx;
  logic [3:0] idx_next;
  logic       out_valid_next;
  uop_t       u;
  logic       skip;

  always_comb begin
    u = uop(world_mode, idx);
    skip = !u.valid ||
           ((world_mode inside {MODE_WALL, MODE_WALL_DAMPER}) && status.ang_neg);
    state_next = state;
    idx_next = idx;
    out_valid_next = out_valid && out_stall;
    cmd.load = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.a_sel = u.a;
    cmd.b_sel = u.b;
    cmd.post_en = 1'b0;
    cmd.post = u.post;
    cmd.out_load = 1'b0;
    cmd.commit = 1'b0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          idx_next = '0;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (skip) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_start = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status.mul_done) begin
          cmd.post_en = 1'b1;
          idx_next = idx + 4'd1;
          state_next = S_ISSUE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.commit = (world_mode inside {MODE_SPRING_MASS, MODE_SPRING_MASS_DAMPER});
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while a result waits");
  a_start_waits: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> (state == S_WAIT))
    else $error("multiply started without waiting for it");
  a_done_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT && status.mul_done) |=> (state == S_ISSUE))
    else $error("finished multiply not followed by the next step");

endmodule

// ===== hdl/haptic_virtual_world_torque_core.sv =====
// Top level: register port, controller and datapath of the haptic virtual world torque core.
//
//   Channel   Signals                               Direction
//   input     in_valid, in_stall, angle, velocity   request in, stall out
//   output    out_valid, out_stall, torque          request out, stall in
//   config    psel, penable, pwrite, paddr, pwdata  register writes and reads
//
// An item runs its products one after another; their number per world is:
// wall and spring 1, spring damper and wall damper 2, spring mass 5, spring mass damper 8.
// A wall or wall damper world with a negative angle runs no product. Each product runs on
// the shared multiplier, which sums four half-width partial products and then saturates.
// Reset clears the registers to their defaults and the mass state to zero.
// A new request is taken while a finished result still waits in the output register.
module haptic_virtual_world_torque_core
  import hvw_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] angle,
  input  logic signed [DATA_WIDTH-1:0] velocity,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] torque,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic [31:0] K_RESET = 32'(1) << FRAC_BITS;
  localparam logic [15:0] T_RESET =
    16'(((1 << FRAC_BITS) + STEP_RESET_NUM) / STEP_RESET_DEN);

  logic [2:0]  world_mode;
  logic [31:0] spring_k;
  logic [31:0] inverse_inertia;
  logic [15:0] step_time;
  logic        wr;
  logic        clear_mass;
  hvw_cmd_t    cmd;
  hvw_status_t status;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign clear_mass = wr && (paddr[3:2] == REG_WORLD_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      world_mode <= MODE_WALL;
      spring_k <= K_RESET;
      inverse_inertia <= K_RESET;
      step_time <= T_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_WORLD_MODE:      world_mode <= pwdata[2:0];
        REG_SPRING_K:        spring_k <= pwdata;
        REG_INVERSE_INERTIA: inverse_inertia <= pwdata;
        REG_STEP_TIME:       step_time <= pwdata[15:0];
        default:             world_mode <= world_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WORLD_MODE:      prdata = 32'(world_mode);
      REG_SPRING_K:        prdata = spring_k;
      REG_INVERSE_INERTIA: prdata = inverse_inertia;
      REG_STEP_TIME:       prdata = 32'(step_time);
      default:             prdata = '0;
    endcase
  end

  hvw_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .world_mode(world_mode),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .cmd(cmd)
  );

  hvw_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .angle(angle),
    .velocity(velocity),
    .spring_k(spring_k),
    .inverse_inertia(inverse_inertia),
    .step_time(step_time),
    .clear_mass(clear_mass),
    .cmd(cmd),
    .status(status),
    .torque(torque)
  );

endmodule
